[rtl/srs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the stereogram row shifter.
// No dependencies; imported by every module of the block but srs_ram.
package srs_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 24;

	localparam int COL_W   = 10;
	localparam int DEPTH_W = 8;
	localparam int PIX_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_LEFT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 3'd4;

	localparam logic [10:0] ROW_WIDTH_RST   = 11'd1024;
	localparam logic [7:0]  STRIP_WIDTH_RST = 8'd64;
	localparam logic [7:0]  DEPTH_SCALE_RST = 8'd16;
	localparam logic        START_LEFT_RST  = 1'b1;
	localparam logic        INVERT_RST      = 1'b0;

	typedef struct packed {
		logic ld;
		logic rd;
		logic j_to_s;
		logic j_to_m;
		logic m_clr;
		logic m_step;
		logic tile_rd;
		logic tile_wr;
		logic step_rd;
		logic step_mul;
		logic step_div;
		logic step_fix;
		logic step_wr;
		logic back;
	} srs_cmd_t;

	typedef struct packed {
		logic s_zero;
		logic left;
		logic j_lt_w;
		logic j_gt_s;
		logic m_fits;
	} srs_sts_t;

endpackage

[rtl/stereogram_row_shifter_top.sv]
`timescale 1ns / 1ps
// Top level of the stereogram row shifter: configuration port, controller, datapath.
// Depends on srs_pkg, srs_ctrl, srs_datapath.
// A word is taken when start is high and busy is low, and a read returns its pixel with
// result_valid in the cycle after it is taken, which the receiver cannot stall. The load
// flagged last_column, unless the strip width is zero, makes the block busy while it tiles
// the row (copying each column from the strip width up to row_width), then, for the
// middle start, searches the start column, then shifts each visited column in one sweep
// from the left or two from the middle. Each visited column passes through the
// registered read of the row memories and the multiply, reciprocal divide-by-255,
// correction and write steps of the shift. Reads before a row is finished give no result.
// Configuration writes are always ready.
module stereogram_row_shifter_top #(
	parameter int MAX_WIDTH  = srs_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = srs_pkg::PIXEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           kind,
	input  logic [srs_pkg::COL_W-1:0]      column,
	input  logic [srs_pkg::DEPTH_W-1:0]    depth_value,
	input  logic [srs_pkg::PIX_W-1:0]      pattern_pixel,
	input  logic                           last_column,
	output logic                           result_valid,
	output logic [srs_pkg::PIX_W-1:0]      pixel,
	output logic [srs_pkg::COL_W-1:0]      column_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data
);

	import srs_pkg::*;

	srs_cmd_t cmd;
	srs_sts_t sts;

	assign cfg_ready = 1'b1;

	srs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.last_column (last_column),
		.busy        (busy),
		.cmd         (cmd),
		.sts         (sts)
	);

	srs_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.column        (column),
		.depth_value   (depth_value),
		.pattern_pixel (pattern_pixel),
		.cfg_valid     (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.pixel         (pixel),
		.column_out    (column_out)
	);

endmodule

[rtl/srs_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/srs_datapath.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, column counters, shift arithmetic and row memories.
// Depends on srs_pkg and srs_ram.
module srs_datapath #(
	parameter int MAX_WIDTH  = srs_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = srs_pkg::PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srs_pkg::srs_cmd_t             cmd,
	output srs_pkg::srs_sts_t             sts,
	input  logic [srs_pkg::COL_W-1:0]     column,
	input  logic [srs_pkg::DEPTH_W-1:0]   depth_value,
	input  logic [srs_pkg::PIX_W-1:0]     pattern_pixel,
	input  logic                          cfg_valid,
	input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          result_valid,
	output logic [srs_pkg::PIX_W-1:0]     pixel,
	output logic [srs_pkg::COL_W-1:0]     column_out
);

	import srs_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int JW = (AW + 1 > 9) ? AW + 1 : 9;
	localparam int SW = JW + 2;

	logic [10:0] row_width_q;
	logic [7:0]  strip_q;
	logic [7:0]  scale_q;
	logic        start_left_q;
	logic        invert_q;

	logic [JW-1:0] j_q;
	logic [JW-1:0] m_q;
	logic [7:0]    k_q;
	logic [15:0]   prod_q;
	logic [7:0]    q0_q;
	logic [7:0]    h_q;
	logic [PIXEL_BITS-1:0] pix_q;

	logic               out_valid_s1;
	logic               oob_s1;
	logic [COL_W-1:0]   col_s1;

	logic [JW-1:0] wsat;
	logic [JW-1:0] half;
	logic [JW:0]   m_sum;
	logic [JW:0]   src_w;
	logic          src_ok;
	logic [SW-1:0] jj, hh, ss, dst;
	logic          dst_ok;
	logic [23:0]   p257;
	logic [16:0]   rem;
	logic          col_in;
	logic [7:0]    k_inc;

	logic                  dep_we, dep_re;
	logic [AW-1:0]         dep_waddr, dep_raddr;
	logic [DEPTH_W-1:0]    dep_rdata;
	logic                  pix_we, pix_re;
	logic [AW-1:0]         pix_waddr, pix_raddr;
	logic [PIXEL_BITS-1:0] pix_wdata, pix_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= ROW_WIDTH_RST;
			strip_q      <= STRIP_WIDTH_RST;
			scale_q      <= DEPTH_SCALE_RST;
			start_left_q <= START_LEFT_RST;
			invert_q     <= INVERT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_WIDTH:   row_width_q  <= cfg_data[10:0];
				REG_STRIP_WIDTH: strip_q      <= cfg_data[7:0];
				REG_DEPTH_SCALE: scale_q      <= cfg_data[7:0];
				REG_START_LEFT:  start_left_q <= cfg_data[0];
				REG_INVERT:      invert_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign wsat = (32'(row_width_q) > 32'(MAX_WIDTH)) ? JW'(MAX_WIDTH) : JW'(row_width_q);
	assign half = wsat >> 1;
	assign m_sum = {1'b0, m_q} + (JW+1)'(strip_q);
	assign src_w = {1'b0, j_q} - (JW+1)'(strip_q);
	assign src_ok = cmd.back | ~src_w[JW];
	assign k_inc = k_q + 8'd1;
	assign col_in = 32'(column) < 32'(MAX_WIDTH);

	assign p257 = 24'({prod_q, 8'd0}) + 24'(prod_q);
	assign rem  = {1'b0, prod_q} - (17'({q0_q, 8'd0}) - 17'(q0_q));

	assign jj = SW'(j_q);
	assign hh = SW'(h_q);
	assign ss = SW'(strip_q);

	always_comb begin
		if (cmd.back) begin
			dst = invert_q ? (jj - hh - ss) : (jj + hh - ss);
		end else begin
			dst = invert_q ? (jj + hh) : (jj - hh);
		end
	end

	assign dst_ok = ~dst[SW-1] && (dst < SW'(wsat));

	assign sts.s_zero = (strip_q == 8'd0);
	assign sts.left   = start_left_q;
	assign sts.j_lt_w = j_q < wsat;
	assign sts.j_gt_s = j_q > JW'(strip_q);
	assign sts.m_fits = m_sum <= {1'b0, half};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			k_q <= '0;
			m_q <= '0;
		end else begin
			if (cmd.j_to_s) begin
				j_q <= JW'(strip_q);
				k_q <= '0;
			end else if (cmd.j_to_m) begin
				j_q <= m_q;
			end else if (cmd.tile_wr) begin
				j_q <= j_q + JW'(1);
				k_q <= (k_inc == strip_q) ? 8'd0 : k_inc;
			end else if (cmd.step_wr) begin
				j_q <= cmd.back ? (j_q - JW'(1)) : (j_q + JW'(1));
			end
			if (cmd.m_clr) begin
				m_q <= '0;
			end else if (cmd.m_step) begin
				m_q <= m_sum[JW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_mul) begin
			prod_q <= {8'd0, dep_rdata} * {8'd0, scale_q};
			pix_q  <= pix_rdata;
		end
		if (cmd.step_div) begin
			q0_q <= p257[23:16];
		end
		if (cmd.step_fix) begin
			h_q <= q0_q + ((rem >= 17'd255) ? 8'd1 : 8'd0);
		end
		if (cmd.rd) begin
			col_s1 <= column;
			oob_s1 <= ~col_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else begin
			out_valid_s1 <= cmd.rd;
		end
	end

	assign dep_we    = cmd.ld & col_in;
	assign dep_waddr = AW'(32'(column));
	assign dep_re    = cmd.step_rd;
	assign dep_raddr = AW'(j_q);

	always_comb begin
		pix_we    = 1'b0;
		pix_waddr = AW'(32'(column));
		pix_wdata = PIXEL_BITS'(32'(pattern_pixel));
		if (cmd.ld) begin
			pix_we = col_in && (column < COL_W'(strip_q));
		end else if (cmd.tile_wr) begin
			pix_we    = 1'b1;
			pix_waddr = AW'(j_q);
			pix_wdata = pix_rdata;
		end else if (cmd.step_wr) begin
			pix_we    = dst_ok & src_ok;
			pix_waddr = AW'(dst);
			pix_wdata = pix_q;
		end
	end

	always_comb begin
		pix_re    = cmd.rd | cmd.tile_rd | cmd.step_rd;
		pix_raddr = AW'(32'(column));
		if (cmd.tile_rd) begin
			pix_raddr = AW'(k_q);
		end else if (cmd.step_rd) begin
			pix_raddr = cmd.back ? AW'(j_q) : AW'(src_w);
		end
	end

	srs_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_WIDTH)) u_depth_ram (
		.clk   (clk),
		.we    (dep_we),
		.waddr (dep_waddr),
		.wdata (depth_value),
		.re    (dep_re),
		.raddr (dep_raddr),
		.rdata (dep_rdata)
	);

	srs_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_pixel_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (pix_wdata),
		.re    (pix_re),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	assign result_valid = out_valid_s1;
	assign pixel        = oob_s1 ? '0 : PIX_W'(32'(pix_rdata));
	assign column_out   = col_s1;

endmodule

[rtl/srs_ctrl.sv]
`timescale 1ns / 1ps
// Controller: accepts words, sequences tiling, middle-start search and shift pass.
// Depends on srs_pkg.
module srs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              kind,
	input  logic              last_column,
	output logic              busy,
	output srs_pkg::srs_cmd_t cmd,
	input  srs_pkg::srs_sts_t sts
);

	import srs_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_TILE_RD = 4'd1;
	localparam logic [3:0] ST_TILE_WR = 4'd2;
	localparam logic [3:0] ST_MID     = 4'd3;
	localparam logic [3:0] ST_RD      = 4'd4;
	localparam logic [3:0] ST_MUL     = 4'd5;
	localparam logic [3:0] ST_DIV     = 4'd6;
	localparam logic [3:0] ST_FIX     = 4'd7;
	localparam logic [3:0] ST_WR      = 4'd8;

	logic [3:0] state_q, state_d;
	logic       row_ready_q;
	logic       back_q;
	logic       ready_set, back_set, back_clr;
	logic       more;

	assign busy = (state_q != ST_IDLE);
	assign more = back_q ? sts.j_gt_s : sts.j_lt_w;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.back  = back_q;
		ready_set = 1'b0;
		back_set  = 1'b0;
		back_clr  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && kind == KIND_LOAD) begin
					cmd.ld = 1'b1;
					if (last_column) begin
						if (sts.s_zero) begin
							ready_set = 1'b1;
						end else begin
							cmd.j_to_s = 1'b1;
							state_d    = ST_TILE_RD;
						end
					end
				end else if (start && kind == KIND_READ) begin
					cmd.rd = row_ready_q;
				end
			end
			ST_TILE_RD: begin
				if (sts.j_lt_w) begin
					cmd.tile_rd = 1'b1;
					state_d     = ST_TILE_WR;
				end else if (sts.left) begin
					cmd.j_to_s = 1'b1;
					state_d    = ST_RD;
				end else begin
					cmd.m_clr = 1'b1;
					state_d   = ST_MID;
				end
			end
			ST_TILE_WR: begin
				cmd.tile_wr = 1'b1;
				state_d     = ST_TILE_RD;
			end
			ST_MID: begin
				if (sts.m_fits) begin
					cmd.m_step = 1'b1;
				end else begin
					cmd.j_to_m = 1'b1;
					state_d    = ST_RD;
				end
			end
			ST_RD: begin
				if (more) begin
					cmd.step_rd = 1'b1;
					state_d     = ST_MUL;
				end else if (!back_q && !sts.left) begin
					back_set   = 1'b1;
					cmd.j_to_m = 1'b1;
				end else begin
					ready_set = 1'b1;
					back_clr  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.step_mul = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.step_div = 1'b1;
				state_d      = ST_FIX;
			end
			ST_FIX: begin
				cmd.step_fix = 1'b1;
				state_d      = ST_WR;
			end
			ST_WR: begin
				cmd.step_wr = 1'b1;
				state_d     = ST_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_ready_q <= 1'b0;
			back_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ready_set) begin
				row_ready_q <= 1'b1;
			end else if (cmd.ld) begin
				row_ready_q <= 1'b0;
			end
			if (back_set) begin
				back_q <= 1'b1;
			end else if (back_clr) begin
				back_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !row_ready_q)
		else $error("row ready while pass runs");

	a_back_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		back_q |-> (state_q == ST_RD || state_q == ST_MUL || state_q == ST_DIV ||
			state_q == ST_FIX || state_q == ST_WR))
		else $error("backward sweep flag outside shift pass");

	a_pass_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld && last_column && !sts.s_zero) |=> (state_q == ST_TILE_RD))
		else $error("last load did not start tiling");

	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(row_ready_q) |-> ($past(state_q) == ST_RD || $past(cmd.ld)))
		else $error("row ready set outside pass end");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of stereogram_row_shifter_top: a directed row, then random rows
// under many register settings, with the sender idling under some; returned pixels checked in order.
// Depends on srs_pkg and the stereogram_row_shifter_top RTL.
module testbench;
	import srs_pkg::*;

	typedef struct packed {
		logic               kind;
		logic [COL_W-1:0]   col;
		logic [DEPTH_W-1:0] depth;
		logic [PIX_W-1:0]   pat;
		logic               last;
	} shifter_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] col;
	} pixel_result_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  start         = 1'b0;
	logic                  busy;
	logic                  kind          = KIND_LOAD;
	logic [COL_W-1:0]      column        = '0;
	logic [DEPTH_W-1:0]    depth_value   = '0;
	logic [PIX_W-1:0]      pattern_pixel = '0;
	logic                  last_column   = 1'b0;
	logic                  result_valid;
	logic [PIX_W-1:0]      pixel;
	logic [COL_W-1:0]      column_out;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	int row_w      = int'(ROW_WIDTH_RST);
	int strip_w    = int'(STRIP_WIDTH_RST);
	int depth_scl  = int'(DEPTH_SCALE_RST);
	bit sweep_left = START_LEFT_RST;
	bit flip       = INVERT_RST;

	logic [DEPTH_W-1:0] depth_mem [MAX_WIDTH_DEF];
	logic [PIX_W-1:0]   pix_mem   [MAX_WIDTH_DEF];
	bit                 row_done = 1'b0;
	bit                 depth_set [MAX_WIDTH_DEF];
	bit                 pix_set   [MAX_WIDTH_DEF];

	shifter_word_t word_queue [$];
	shifter_word_t cur_word;
	pixel_result_t pixel_expect [$];

	int send_idle_pct = 0;
	int items_sent    = 0;
	int settings      = 0;
	int checked       = 0;
	int mismatches    = 0;

	stereogram_row_shifter_top i_dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int shift_at(input int j);
		return int'(depth_mem[j]) * depth_scl / 255;
	endfunction

	function automatic void move_pixel(input int dst, input int src, input int w);
		if (dst >= 0 && dst < w && src >= 0 && src < w)
			pix_mem[dst] = pix_mem[src];
	endfunction

	function automatic void apply_word(input shifter_word_t wd);
		int w, s, dir, j, m;
		pixel_result_t res;
		w = (row_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : row_w;
		s = strip_w;
		dir = flip ? -1 : 1;
		if (wd.kind == KIND_READ) begin
			if (row_done) begin
				res.pixel = pix_mem[wd.col];
				res.col = wd.col;
				pixel_expect.push_back(res);
			end
			return;
		end
		row_done = 1'b0;
		depth_mem[wd.col] = wd.depth;
		if (wd.col < s)
			pix_mem[wd.col] = wd.pat;
		if (!wd.last)
			return;
		row_done = 1'b1;
		if (s == 0)
			return;
		for (j = s; j < w; j++)
			pix_mem[j] = pix_mem[j % s];
		m = sweep_left ? s : (w / 2 / s) * s;
		for (j = m; j < w; j++)
			move_pixel(j - shift_at(j) * dir, j - s, w);
		if (!sweep_left)
			for (j = m; j > s; j--)
				move_pixel(j + shift_at(j) * dir - s, j, w);
	endfunction

	always @(posedge clk) begin : drive_words
		shifter_word_t nxt;
		logic free;
		if (arst_n) begin
			free = !start;
			if (start && !busy) begin
				apply_word(cur_word);
				free = 1'b1;
			end
			if (free) begin
				if (word_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = word_queue.pop_front();
					cur_word <= nxt;
					kind <= nxt.kind;
					column <= nxt.col;
					depth_value <= nxt.depth;
					pattern_pixel <= nxt.pat;
					last_column <= nxt.last;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_pixels
		pixel_result_t want;
		if (arst_n && result_valid) begin
			checked++;
			if (pixel_expect.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected pixel %h for column %0d", pixel, column_out);
				mismatches++;
			end else begin
				want = pixel_expect.pop_front();
				if (pixel !== want.pixel || column_out !== want.col) begin
					if (mismatches < 10)
						$display("mismatch: expected pixel %h column %0d, got pixel %h column %0d",
							want.pixel, want.col, pixel, column_out);
					mismatches++;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ROW_WIDTH:   row_w = value;
			REG_STRIP_WIDTH: strip_w = value;
			REG_DEPTH_SCALE: depth_scl = value;
			REG_START_LEFT:  sweep_left = value[0];
			REG_INVERT:      flip = value[0];
			default: ;
		endcase
	endtask

	task automatic set_mode(input int w, input int s, input int scale, input bit left,
		input bit inv);
		write_reg(REG_ROW_WIDTH, w);
		write_reg(REG_STRIP_WIDTH, s);
		write_reg(REG_DEPTH_SCALE, scale);
		write_reg(REG_START_LEFT, int'(left));
		write_reg(REG_INVERT, int'(inv));
	endtask

	task automatic queue_word(input logic kd, input int col, input int dv, input int pp,
		input bit last);
		shifter_word_t wd;
		wd.kind = kd;
		wd.col = col[COL_W-1:0];
		wd.depth = dv[DEPTH_W-1:0];
		wd.pat = pp[PIX_W-1:0];
		wd.last = last;
		if (kd == KIND_LOAD) begin
			depth_set[col] = 1'b1;
			if (col < strip_w)
				pix_set[col] = 1'b1;
			if (last)
				for (int c = 0; c < row_w; c++)
					pix_set[c] = 1'b1;
		end
		word_queue.push_back(wd);
		items_sent++;
	endtask

	// load every column the pass would read unwritten, plus a few extras, in random order
	task automatic queue_row();
		int cols[$];
		int c, k, r, t, dv, pp;
		for (c = 0; c < row_w; c++)
			if (!depth_set[c] || (c < strip_w && !pix_set[c]))
				cols.push_back(c);
		repeat ($urandom_range(1, 6))
			cols.push_back(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
				: $urandom_range(0, row_w - 1));
		for (k = cols.size() - 1; k > 0; k--) begin
			r = $urandom_range(0, k);
			t = cols[k];
			cols[k] = cols[r];
			cols[r] = t;
		end
		for (k = 0; k < cols.size(); k++) begin
			c = $urandom_range(0, row_w - 1);
			if ($urandom_range(0, 11) == 0 && pix_set[c])
				queue_word(KIND_READ, c, $urandom, $urandom, 1'($urandom_range(0, 1)));
			r = $urandom_range(0, 5);
			dv = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255);
			pp = (r == 2) ? 0 : (r == 3) ? 24'hFFFFFF : $urandom;
			queue_word(KIND_LOAD, cols[k], dv, pp, k == cols.size() - 1);
		end
		repeat ($urandom_range(2, 8)) begin
			c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
				: $urandom_range(0, row_w - 1);
			if (pix_set[c])
				queue_word(KIND_READ, c, $urandom, $urandom, 1'($urandom_range(0, 1)));
		end
	endtask

	// hold until every word is taken and answered, then let a full pass finish
	task automatic drain_words();
		do @(posedge clk); while (word_queue.size() != 0 || start || pixel_expect.size() != 0);
		repeat (8 * row_w + 64) @(posedge clk);
	endtask

	task automatic run_phase(input int w, input int s, input int scale, input bit left,
		input bit inv);
		set_mode(w, s, scale, left, inv);
		case (settings % 4)
			1: send_idle_pct = 61;
			3: send_idle_pct = 24;
			default: send_idle_pct = 0;
		endcase
		settings++;
		repeat ($urandom_range(2, 5))
			queue_row();
		drain_words();
	endtask

	initial begin : stimulus
		int r, w, s;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(8, 3, 255, 1'b1, 1'b0);
		queue_word(KIND_LOAD, 0, 0, 0, 1'b0);
		queue_word(KIND_READ, 0, 255, 24'hFFFFFF, 1'b1);
		queue_word(KIND_LOAD, 1, 255, 24'hFFFFFF, 1'b0);
		queue_word(KIND_LOAD, 2, 128, 24'h123456, 1'b0);
		for (int c = 3; c < 7; c++)
			queue_word(KIND_LOAD, c, (c % 2) ? 255 : 1, $urandom, 1'b0);
		queue_word(KIND_LOAD, 7, 255, 24'h0F0F0F, 1'b1);
		for (int c = 0; c < 8; c++)
			queue_word(KIND_READ, c, 0, 0, 1'b0);
		queue_word(KIND_LOAD, 1023, 255, 24'hFFFFFF, 1'b0);
		queue_word(KIND_READ, 3, 0, 0, 1'b0);
		queue_word(KIND_LOAD, 4, 0, 24'h000001, 1'b1);
		queue_word(KIND_READ, 4, 0, 0, 1'b0);
		queue_word(KIND_READ, 7, 0, 0, 1'b0);
		drain_words();

		run_phase(1, 1, 0, 1'b0, 1'b0);
		run_phase(20, 255, 255, 1'b0, 1'b1);
		run_phase(37, 5, 255, 1'b1, 1'b1);
		while (items_sent < 600) begin
			r = $urandom_range(0, 9);
			w = (r == 0) ? 1 : (r < 7) ? $urandom_range(2, 40) : $urandom_range(41, 200);
			r = $urandom_range(0, 5);
			s = (r == 0) ? 1 : (r == 1) ? 255 : (r == 2) ? $urandom_range(1, 255)
				: $urandom_range(1, (w < 40) ? w : 40);
			r = $urandom_range(0, 4);
			run_phase(w, s, (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		run_phase(320, 255, 255, 1'b1, 1'b0);
		run_phase(320, 1, 200, 1'b0, 1'b1);

		$display("%0d words driven under %0d register settings; %0d pixels compared, %0d bad",
			items_sent, settings + 1, checked, mismatches);
		if (mismatches == 0 && pixel_expect.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/srs_datapath.sv
rtl/srs_ctrl.sv
rtl/stereogram_row_shifter_top.sv
tb/sv/testbench.sv
